// ----- sv/spct_pkg.sv -----
// Shared types and codes of the shape pair collision test unit.
// Used by the segment lanes, the pair unit and the top level; depends on nothing.
`timescale 1ns / 1ps
package spct_pkg;

  // Pair selected by one transaction
  typedef enum logic [1:0] {
    OP_AABB     = 2'd0,
    OP_CIRCLE   = 2'd1,
    OP_CIRC_BOX = 2'd2,
    OP_SEG_CIRC = 2'd3
  } op_e;

  // Segment lanes: one per box edge, lane 0 also serves the segment pair
  localparam int unsigned NumLanes  = 4;
  // Register stages from input to output register
  localparam int unsigned PipeDepth = 6;

  // Sign and zero flags of the quadratic in one segment lane
  typedef struct packed {
    logic a_zero;
    logic c_neg;
    logic c_zero;
    logic f1_neg;
    logic f1_zero;
    logic hb_neg;
    logic ahb_pos;
  } seg_flags_t;

  // Flags of the box and circle pair tests
  typedef struct packed {
    logic aabb_hit;
    logic cc_hit;
    logic in_box;
  } pair_flags_t;

endpackage

// ----- sv/spct_seg_lane.sv -----
// Five-stage segment versus circle crossing test, exact and without square root.
// Depends on spct_pkg for the flag struct.
`timescale 1ns / 1ps
module spct_seg_lane #(
  parameter int unsigned W = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] x0_i,
  input  logic signed [W-1:0] y0_i,
  input  logic signed [W-1:0] x1_i,
  input  logic signed [W-1:0] y1_i,
  input  logic signed [W-1:0] cx_i,
  input  logic signed [W-1:0] cy_i,
  input  logic signed [W-1:0] r_i,
  output logic                hit_o
);

  localparam int unsigned DW = W + 2;
  localparam int unsigned PW = 2 * W + 6;
  localparam int unsigned MW = PW - 1;
  localparam int unsigned HW = (MW + 1) / 2;
  localparam int unsigned QW = 4 * HW;

  // Stage 1: offsets from the center and direction
  logic signed [DW-1:0] sx_q, sy_q, dx_q, dy_q;
  logic signed [W-1:0]  r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= DW'(x0_i) - DW'(cx_i);
      sy_q <= DW'(y0_i) - DW'(cy_i);
      dx_q <= DW'(x1_i) - DW'(x0_i);
      dy_q <= DW'(y1_i) - DW'(y0_i);
      r_q  <= r_i;
    end
  end

  // Stage 2: quadratic coefficients, cross product and squared radius
  logic signed [PW-1:0] sxe, sye, dxe, dye, re;
  logic signed [PW-1:0] a_q, hb_q, c_q, cross_q, r2_q;

  assign sxe = PW'(sx_q);
  assign sye = PW'(sy_q);
  assign dxe = PW'(dx_q);
  assign dye = PW'(dy_q);
  assign re  = PW'(r_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= dxe * dxe + dye * dye;
      hb_q    <= sxe * dxe + sye * dye;
      c_q     <= sxe * sxe + sye * sye - re * re;
      cross_q <= sxe * dye - sye * dxe;
      r2_q    <= re * re;
    end
  end

  // Stage 3: flags and partial products of cross^2 and a*r^2
  logic [MW-1:0]        cm, am, rm;
  logic [2*HW-1:0]      ch, cl, ah, al, rh, rl;
  logic signed [PW-1:0] f1, ahb;
  spct_pkg::seg_flags_t fl_d, fl3_q, fl4_q;
  logic [2*HW-1:0]      pp_hh_q, pp_hl_q, pp_ll_q;
  logic [2*HW-1:0]      qq_hh_q, qq_hl_q, qq_lh_q, qq_ll_q;

  assign cm = cross_q[PW-1] ? MW'(-cross_q) : MW'(cross_q);
  assign am = MW'(a_q);
  assign rm = MW'(r2_q);
  assign ch = (2*HW)'(cm >> HW);
  assign cl = (2*HW)'(cm[HW-1:0]);
  assign ah = (2*HW)'(am >> HW);
  assign al = (2*HW)'(am[HW-1:0]);
  assign rh = (2*HW)'(rm >> HW);
  assign rl = (2*HW)'(rm[HW-1:0]);
  assign f1  = a_q + (hb_q <<< 1) + c_q;
  assign ahb = a_q + hb_q;

  always_comb begin
    fl_d.a_zero  = (a_q == '0);
    fl_d.c_neg   = c_q[PW-1];
    fl_d.c_zero  = (c_q == '0);
    fl_d.f1_neg  = f1[PW-1];
    fl_d.f1_zero = (f1 == '0);
    fl_d.hb_neg  = hb_q[PW-1];
    fl_d.ahb_pos = !ahb[PW-1] && (ahb != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl3_q   <= fl_d;
      pp_hh_q <= ch * ch;
      pp_hl_q <= ch * cl;
      pp_ll_q <= cl * cl;
      qq_hh_q <= ah * rh;
      qq_hl_q <= ah * rl;
      qq_lh_q <= al * rh;
      qq_ll_q <= al * rl;
    end
  end

  // Stage 4: assemble the two wide products
  logic [QW-1:0] cross2_q, ar2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl4_q    <= fl3_q;
      cross2_q <= (QW'(pp_hh_q) << (2 * HW)) + (QW'(pp_hl_q) << (HW + 1)) + QW'(pp_ll_q);
      ar2_q    <= (QW'(qq_hh_q) << (2 * HW)) + (QW'(qq_hl_q) << HW)
                + (QW'(qq_lh_q) << HW) + QW'(qq_ll_q);
    end
  end

  // Stage 5: root in the open interval, from the signs of f(0), f(1)
  logic hit_d, hit_q;

  always_comb begin
    if (fl4_q.a_zero) begin
      hit_d = 1'b0;
    end else if (fl4_q.c_neg) begin
      hit_d = !fl4_q.f1_neg && !fl4_q.f1_zero;
    end else if (fl4_q.c_zero) begin
      hit_d = fl4_q.hb_neg && !fl4_q.f1_neg && !fl4_q.f1_zero;
    end else if (fl4_q.f1_neg) begin
      hit_d = 1'b1;
    end else if (fl4_q.f1_zero) begin
      hit_d = fl4_q.ahb_pos;
    end else begin
      // both roots on one side: need a real pair with the vertex inside
      hit_d = (ar2_q > cross2_q) && fl4_q.hb_neg && fl4_q.ahb_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- sv/spct_pair_unit.sv -----
// Box pair, circle pair and center-in-box tests, aligned to five stages.
// Depends on spct_pkg for the flag struct.
`timescale 1ns / 1ps
module spct_pair_unit #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_x0_i,
  input  logic signed [W-1:0]   a_y0_i,
  input  logic signed [W-1:0]   a_x1_i,
  input  logic signed [W-1:0]   a_y1_i,
  input  logic signed [W-1:0]   b_x0_i,
  input  logic signed [W-1:0]   b_y0_i,
  input  logic signed [W-1:0]   b_x1_i,
  input  logic signed [W-1:0]   b_y1_i,
  output spct_pkg::pair_flags_t flags_o,
  output logic signed [W+1:0]   sep_x_o,
  output logic signed [W+1:0]   sep_y_o
);

  localparam int unsigned EW = W + 3;
  localparam int unsigned SW = W + 2;
  localparam int unsigned PW = 2 * W + 6;

  // Stage 1: doubled center offsets and extents, circle offsets, inside test
  logic signed [EW-1:0] ddx_q, ddy_q, shx_q, shy_q, cdx_q, cdy_q, rs_q;
  logic                 inside1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ddx_q <= (EW'(a_x0_i) + EW'(a_x1_i)) - (EW'(b_x0_i) + EW'(b_x1_i));
      ddy_q <= (EW'(a_y0_i) + EW'(a_y1_i)) - (EW'(b_y0_i) + EW'(b_y1_i));
      shx_q <= (EW'(a_x1_i) - EW'(a_x0_i)) + (EW'(b_x1_i) - EW'(b_x0_i));
      shy_q <= (EW'(a_y1_i) - EW'(a_y0_i)) + (EW'(b_y1_i) - EW'(b_y0_i));
      cdx_q <= EW'(b_x0_i) - EW'(a_x0_i);
      cdy_q <= EW'(b_y0_i) - EW'(a_y0_i);
      rs_q  <= EW'(a_x1_i) + EW'(b_x1_i);
      inside1_q <= (a_x0_i >= b_x0_i) && (a_x0_i <= b_x1_i)
                && (a_y0_i >= b_y0_i) && (a_y0_i <= b_y1_i);
    end
  end

  // Stage 2: box overlap and separation, circle squares
  logic signed [EW-1:0] adx, ady, ox, oy;
  logic signed [SW-1:0] sx_d, sy_d, sx2_q, sy2_q;
  logic                 ahit_d, ahit2_q, inside2_q;
  logic signed [PW-1:0] cdxe, cdye, rse, d2_q, rs2_q;

  assign adx = ddx_q[EW-1] ? -ddx_q : ddx_q;
  assign ady = ddy_q[EW-1] ? -ddy_q : ddy_q;
  assign ox  = shx_q - adx;
  assign oy  = shy_q - ady;
  assign ahit_d = (adx < shx_q) && (ady < shy_q);

  always_comb begin
    sx_d = '0;
    sy_d = '0;
    if (ahit_d) begin
      // keep the shorter axis, y on a tie
      if (ox < oy) begin
        sx_d = SW'(ddx_q[EW-1] ? -ox : ox);
      end else begin
        sy_d = SW'(ddy_q[EW-1] ? -oy : oy);
      end
    end
  end

  assign cdxe = PW'(cdx_q);
  assign cdye = PW'(cdy_q);
  assign rse  = PW'(rs_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ahit2_q   <= ahit_d;
      sx2_q     <= sx_d;
      sy2_q     <= sy_d;
      inside2_q <= inside1_q;
      d2_q      <= cdxe * cdxe + cdye * cdye;
      rs2_q     <= rse * rse;
    end
  end

  // Stages 3 to 5: circle compare, then hold to line up with the lanes
  spct_pkg::pair_flags_t fl3_q, fl4_q, fl5_q;
  logic signed [SW-1:0]  sx3_q, sy3_q, sx4_q, sy4_q, sx5_q, sy5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl3_q.aabb_hit <= ahit2_q;
      fl3_q.cc_hit   <= d2_q < rs2_q;
      fl3_q.in_box   <= inside2_q;
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      fl4_q <= fl3_q;
      sx4_q <= sx3_q;
      sy4_q <= sy3_q;
      fl5_q <= fl4_q;
      sx5_q <= sx4_q;
      sy5_q <= sy4_q;
    end
  end

  assign flags_o = fl5_q;
  assign sep_x_o = sx5_q;
  assign sep_y_o = sy5_q;

endmodule

// ----- sv/shape_pair_collision_test_unit.sv -----
// Top level of the shape pair collision test unit: input steering, pipeline control, output.
// Depends on spct_pkg, spct_seg_lane and spct_pair_unit.
`timescale 1ns / 1ps
// Tests one pair of 2D shapes per transaction: box/box (with a separation vector in half
// units along the shorter overlap axis), circle/circle, circle/box and segment/circle.
// The unit is a six-stage pipeline that takes a new transaction every cycle while the
// output is not stalled; back pressure on the output stalls all stages together without
// losing or repeating anything. The depth is set by the segment lanes, which split the
// wide discriminant products into partial products over two stages. Separation is
// nonzero only for a box pair that overlaps.
module shape_pair_collision_test_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [COORD_WIDTH-1:0] a_x0_i,
  input  logic signed [COORD_WIDTH-1:0] a_y0_i,
  input  logic signed [COORD_WIDTH-1:0] a_x1_i,
  input  logic signed [COORD_WIDTH-1:0] a_y1_i,
  input  logic signed [COORD_WIDTH-1:0] b_x0_i,
  input  logic signed [COORD_WIDTH-1:0] b_y0_i,
  input  logic signed [COORD_WIDTH-1:0] b_x1_i,
  input  logic signed [COORD_WIDTH-1:0] b_y1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH+1:0] sep_x_o,
  output logic signed [COORD_WIDTH+1:0] sep_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = W + 2;
  localparam int unsigned ND = spct_pkg::PipeDepth;
  localparam int unsigned NL = spct_pkg::NumLanes;

  // Advance the whole pipe whenever the output slot is free or drains
  logic          en;
  logic [ND-1:0] vld_q;

  assign en         = !vld_q[ND-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ND-2:0], in_valid_i};
    end
  end

  // Steer box edges (or the segment) into the lanes
  logic signed [W-1:0] lx0 [NL], ly0 [NL], lx1 [NL], ly1 [NL];
  logic signed [W-1:0] lcx, lcy, lr;
  logic [NL-1:0]       lane_hit;

  always_comb begin
    lx0[0] = b_x0_i; ly0[0] = b_y0_i; lx1[0] = b_x0_i; ly1[0] = b_y1_i;
    lx0[1] = b_x0_i; ly0[1] = b_y1_i; lx1[1] = b_x1_i; ly1[1] = b_y1_i;
    lx0[2] = b_x1_i; ly0[2] = b_y1_i; lx1[2] = b_x1_i; ly1[2] = b_y0_i;
    lx0[3] = b_x1_i; ly0[3] = b_y0_i; lx1[3] = b_x0_i; ly1[3] = b_y0_i;
    lcx = a_x0_i;
    lcy = a_y0_i;
    lr  = a_x1_i;
    if (spct_pkg::op_e'(operation_i) == spct_pkg::OP_SEG_CIRC) begin
      lx0[0] = a_x0_i; ly0[0] = a_y0_i; lx1[0] = a_x1_i; ly1[0] = a_y1_i;
      lcx = b_x0_i;
      lcy = b_y0_i;
      lr  = b_x1_i;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    spct_seg_lane #(.W(W)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .x0_i  (lx0[g]),
      .y0_i  (ly0[g]),
      .x1_i  (lx1[g]),
      .y1_i  (ly1[g]),
      .cx_i  (lcx),
      .cy_i  (lcy),
      .r_i   (lr),
      .hit_o (lane_hit[g])
    );
  end

  spct_pkg::pair_flags_t pflags;
  logic signed [SW-1:0]  psx, psy;

  spct_pair_unit #(.W(W)) u_pair (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_x0_i  (a_x0_i),
    .a_y0_i  (a_y0_i),
    .a_x1_i  (a_x1_i),
    .a_y1_i  (a_y1_i),
    .b_x0_i  (b_x0_i),
    .b_y0_i  (b_y0_i),
    .b_x1_i  (b_x1_i),
    .b_y1_i  (b_y1_i),
    .flags_o (pflags),
    .sep_x_o (psx),
    .sep_y_o (psy)
  );

  // Carry the operation alongside the data
  spct_pkg::op_e op_q [ND-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[0] <= spct_pkg::op_e'(operation_i);
      for (int i = 1; i < ND - 1; i++) begin
        op_q[i] <= op_q[i-1];
      end
    end
  end

  // Select the result for the operation and hold it in the output register
  logic                 hit_d, hit_q;
  logic signed [SW-1:0] sx_d, sy_d, sx_q, sy_q;

  always_comb begin
    hit_d = 1'b0;
    sx_d  = '0;
    sy_d  = '0;
    case (op_q[ND-2])
      spct_pkg::OP_AABB: begin
        hit_d = pflags.aabb_hit;
        sx_d  = psx;
        sy_d  = psy;
      end
      spct_pkg::OP_CIRCLE:   hit_d = pflags.cc_hit;
      spct_pkg::OP_CIRC_BOX: hit_d = pflags.in_box || (|lane_hit);
      spct_pkg::OP_SEG_CIRC: hit_d = lane_hit[0];
      default:               hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
    end
  end

  assign out_valid_o = vld_q[ND-1];
  assign hit_o       = hit_q;
  assign sep_x_o     = sx_q;
  assign sep_y_o     = sy_q;

  // Checks
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow the output slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(sep_x_o))
    else $error("stalled result changed");

  a_sep_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (sep_x_o == '0) && (sep_y_o == '0))
    else $error("separation without a hit");

  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sep_x_o == '0) || (sep_y_o == '0))
    else $error("separation on both axes");

  a_accept_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction lost at entry");

endmodule
